// ----- src/mmixeu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmixeu_pkg
// Shared types and constants of the integer execute unit.
// ----------------------------------------------------------------------------
package mmixeu_pkg;

  localparam int unsigned DivSteps = 64;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_ILLEGAL   = 2'd1;
  localparam logic [1:0] ST_ELSEWHERE = 2'd2;

  typedef enum logic [1:0] {
    KIND_ALU  = 2'd0,
    KIND_MUL  = 2'd1,
    KIND_SDIV = 2'd2,
    KIND_UDIV = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0]  cmd;
    logic [7:0]  op_x;
    logic [7:0]  op_y;
    logic [7:0]  op_z;
    logic [63:0] x_value;
    logic [63:0] y_value;
    logic [63:0] z_value;
    logic [63:0] pc;
    logic [63:0] mux_mask;
  } instr_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] result;
    logic        wr;
    logic [63:0] npc;
    logic [1:0]  st;
    logic [31:0] cross_a;
    logic [31:0] cross_b;
    logic        neg;
    logic        dz;
    logic [63:0] dvd;
    logic [63:0] dvs;
  } alu_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] result;
    logic        wr;
    logic [63:0] npc;
    logic [1:0]  st;
    logic        neg;
    logic        dz;
  } pipe_t;

endpackage

// ----- src/mmixeu_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmixeu_alu
// Operand selection and combinational integer operations; multiply partial
// products and divide operand preparation.
// ----------------------------------------------------------------------------
module mmixeu_alu (
  input  mmixeu_pkg::instr_t in_i,
  output mmixeu_pkg::alu_t   out_o
);
  import mmixeu_pkg::*;

  logic [7:0]  cmd;
  logic [63:0] y, z, xv, pc, mask, yz64, wyde, off16, off24, mor_r, mxor_r, pc4;
  logic [63:0] ll, yabs, zabs;
  logic [31:0] hl, lh;
  logic        cond_x, cond_y, sgn;

  function automatic logic cond_holds(logic [2:0] c, logic [63:0] v);
    logic n, zr, od;
    n  = v[63];
    zr = (v == 64'd0);
    od = v[0];
    case (c)
      3'd0:    cond_holds = n;
      3'd1:    cond_holds = zr;
      3'd2:    cond_holds = !n && !zr;
      3'd3:    cond_holds = od;
      3'd4:    cond_holds = !n;
      3'd5:    cond_holds = !zr;
      3'd6:    cond_holds = n || zr;
      default: cond_holds = !od;
    endcase
  endfunction

  assign cmd   = in_i.cmd;
  assign y     = in_i.y_value;
  assign xv    = in_i.x_value;
  assign pc    = in_i.pc;
  assign mask  = in_i.mux_mask;
  assign z     = cmd[0] ? {56'd0, in_i.op_z} : in_i.z_value;
  assign yz64  = {48'd0, in_i.op_y, in_i.op_z};
  assign wyde  = yz64 << {~cmd[1:0], 4'd0};
  assign off16 = {{46{cmd[0]}}, in_i.op_y, in_i.op_z, 2'b00};
  assign off24 = {{38{cmd[0]}}, in_i.op_x, in_i.op_y, in_i.op_z, 2'b00};
  assign pc4   = pc + 64'd4;
  assign cond_x = cond_holds(cmd[3:1], xv);
  assign cond_y = cond_holds(cmd[3:1], y);

  assign ll = {32'd0, y[31:0]} * {32'd0, z[31:0]};
  assign hl = y[63:32] * z[31:0];
  assign lh = y[31:0] * z[63:32];

  assign sgn  = (cmd[1] == 1'b0);
  assign yabs = (sgn && y[63]) ? (64'd0 - y) : y;
  assign zabs = (sgn && z[63]) ? (64'd0 - z) : z;

  always_comb begin
    mor_r  = '0;
    mxor_r = '0;
    for (int j = 0; j < 8; j++) begin
      for (int k = 0; k < 8; k++) begin
        for (int i = 0; i < 8; i++) begin
          mor_r[8*j+k]  = mor_r[8*j+k]  | (y[8*i+k] & z[8*j+i]);
          mxor_r[8*j+k] = mxor_r[8*j+k] ^ (y[8*i+k] & z[8*j+i]);
        end
      end
    end
  end

  always_comb begin
    out_o         = '0;
    out_o.kind    = KIND_ALU;
    out_o.wr      = 1'b1;
    out_o.npc     = pc4;
    out_o.st      = ST_DONE;
    out_o.neg     = sgn && (y[63] ^ z[63]);
    out_o.dz      = (z == 64'd0);
    out_o.dvd     = yabs;
    out_o.dvs     = zabs;
    unique case (cmd) inside
      [8'h18:8'h1b]: begin
        out_o.kind    = KIND_MUL;
        out_o.result  = ll;
        out_o.cross_a = hl;
        out_o.cross_b = lh;
      end
      [8'h1c:8'h1d]: out_o.kind = KIND_SDIV;
      [8'h1e:8'h1f]: out_o.kind = KIND_UDIV;
      [8'h20:8'h23]: out_o.result = y + z;
      [8'h24:8'h27]: out_o.result = y - z;
      [8'h28:8'h2f]: out_o.result = (y << ({1'b0, cmd[2:1]} + 3'd1)) + z;
      [8'h30:8'h31]: out_o.result = ($signed(y) > $signed(z)) ? 64'd1 :
                                    (($signed(y) < $signed(z)) ? '1 : 64'd0);
      [8'h32:8'h33]: out_o.result = (y > z) ? 64'd1 : ((y < z) ? '1 : 64'd0);
      [8'h34:8'h37]: out_o.result = {56'd0, in_i.op_y} - z;
      [8'h38:8'h3b]: out_o.result = (|z[63:6]) ? 64'd0 : (y << z[5:0]);
      [8'h3c:8'h3d]: out_o.result = (|z[63:6]) ? {64{y[63]}} :
                                    64'($signed(y) >>> z[5:0]);
      [8'h3e:8'h3f]: out_o.result = (|z[63:6]) ? 64'd0 : (y >> z[5:0]);
      [8'h40:8'h5f]: begin
        out_o.wr = 1'b0;
        if (cond_x) out_o.npc = pc + off16;
      end
      [8'h60:8'h6f]: begin
        if (cond_y) begin
          out_o.result = z;
        end else begin
          out_o.result = xv;
          out_o.wr     = 1'b0;
        end
      end
      [8'h70:8'h7f]: out_o.result = cond_y ? z : 64'd0;
      [8'h80:8'h8f], 8'h92, 8'h93, 8'h96, 8'h97, 8'h9e, 8'h9f, [8'ha0:8'haf],
      [8'hb2:8'hb7], 8'hbe, 8'hbf, 8'hf2, 8'hf3, [8'hf6:8'hf8], 8'hfe:
        out_o.st = ST_ELSEWHERE;
      [8'h9a:8'h9d], 8'hba, 8'hbb, 8'hfd: out_o.wr = 1'b0;
      [8'hc0:8'hcf]: begin
        case (cmd[3:1])
          3'd0:    out_o.result = y | z;
          3'd1:    out_o.result = y | ~z;
          3'd2:    out_o.result = ~(y | z);
          3'd3:    out_o.result = y ^ z;
          3'd4:    out_o.result = y & z;
          3'd5:    out_o.result = y & ~z;
          3'd6:    out_o.result = ~(y & z);
          default: out_o.result = ~(y ^ z);
        endcase
      end
      [8'hd8:8'hd9]: out_o.result = (y & mask) | (z & ~mask);
      [8'hdc:8'hdd]: out_o.result = mor_r;
      [8'hde:8'hdf]: out_o.result = mxor_r;
      [8'he0:8'he3]: out_o.result = wyde;
      [8'he4:8'he7]: out_o.result = xv + wyde;
      [8'he8:8'heb]: out_o.result = xv | wyde;
      [8'hec:8'hef]: out_o.result = xv & wyde;
      [8'hf0:8'hf1]: begin
        out_o.wr  = 1'b0;
        out_o.npc = pc + off24;
      end
      [8'hf4:8'hf5]: out_o.result = pc + off16;
      default: out_o.st = ST_ILLEGAL;
    endcase
    if (out_o.st != ST_DONE) begin
      out_o.kind   = KIND_ALU;
      out_o.result = '0;
      out_o.wr     = 1'b0;
      out_o.npc    = pc4;
    end
  end

endmodule

// ----- src/mmix_integer_execute_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmix_integer_execute_unit
// Pipelined MMIX integer execute stage with a one-bit-per-stage divider.
//
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    cmd, op_x/y/z, x/y/z_value, pc, mux_mask
// out      output     out_valid_o / out_stall_i  result, writes_result, next_pc, status
//
// One transaction per cycle while in_stall_o is low. Each passes the input and ALU
// registers and the 64-stage restoring divider (every op runs through it).
// A two-entry output buffer takes results; input stalls only when it is full.
// Reset clears all valid bits and the buffer.
// ----------------------------------------------------------------------------
module mmix_integer_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  cmd_i,
  input  logic [7:0]  op_x_i,
  input  logic [7:0]  op_y_i,
  input  logic [7:0]  op_z_i,
  input  logic [63:0] x_value_i,
  input  logic [63:0] y_value_i,
  input  logic [63:0] z_value_i,
  input  logic [63:0] pc_i,
  input  logic [63:0] mux_mask_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_o,
  output logic        writes_result_o,
  output logic [63:0] next_pc_o,
  output logic [1:0]  status_o
);
  import mmixeu_pkg::*;

  logic        en, push, pop;
  logic        v1_q, v2_q;
  instr_t      in_q;
  alu_t        alu_d, alu_q;
  logic        pv_q  [DivSteps+1];
  pipe_t       pipe_q[DivSteps+1];
  logic [63:0] rem_q [DivSteps+1];
  logic [63:0] dvd_q [DivSteps+1];
  logic [63:0] dvs_q [DivSteps+1];
  pipe_t       fin;
  logic [63:0] quo;
  logic [63:0] res_d;
  logic [63:0] buf_res_q[2];
  logic        buf_wr_q [2];
  logic [63:0] buf_npc_q[2];
  logic [1:0]  buf_st_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  count_q;

  assign en         = (count_q != 2'd2);
  assign in_stall_o = !en;
  assign push       = en && pv_q[DivSteps];
  assign pop        = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q  <= '{cmd: cmd_i, op_x: op_x_i, op_y: op_y_i, op_z: op_z_i,
                 x_value: x_value_i, y_value: y_value_i, z_value: z_value_i,
                 pc: pc_i, mux_mask: mux_mask_i};
      alu_q <= alu_d;
    end
  end

  mmixeu_alu u_alu (
    .in_i  (in_q),
    .out_o (alu_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q[0] <= 1'b0;
    end else if (en) begin
      pv_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q[0].kind   <= alu_q.kind;
      pipe_q[0].result <= alu_q.result + {alu_q.cross_a + alu_q.cross_b, 32'd0};
      pipe_q[0].wr     <= alu_q.wr;
      pipe_q[0].npc    <= alu_q.npc;
      pipe_q[0].st     <= alu_q.st;
      pipe_q[0].neg    <= alu_q.neg;
      pipe_q[0].dz     <= alu_q.dz;
      rem_q[0]         <= '0;
      dvd_q[0]         <= alu_q.dvd;
      dvs_q[0]         <= alu_q.dvs;
    end
  end

  for (genvar k = 1; k <= DivSteps; k++) begin : g_div
    logic [64:0] trial;
    logic        ge;
    assign trial = {rem_q[k-1], dvd_q[k-1][63]};
    assign ge    = (trial >= {1'b0, dvs_q[k-1]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[k] <= 1'b0;
      end else if (en) begin
        pv_q[k] <= pv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pipe_q[k] <= pipe_q[k-1];
        rem_q[k]  <= ge ? 64'(trial - {1'b0, dvs_q[k-1]}) : trial[63:0];
        dvd_q[k]  <= {dvd_q[k-1][62:0], ge};
        dvs_q[k]  <= dvs_q[k-1];
      end
    end
  end

  assign fin = pipe_q[DivSteps];
  assign quo = dvd_q[DivSteps];

  always_comb begin
    case (fin.kind)
      KIND_SDIV: res_d = fin.dz ? 64'd0 : (fin.neg ? (64'd0 - quo) : quo);
      KIND_UDIV: res_d = fin.dz ? 64'd0 : quo;
      default:   res_d = fin.result;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_res_q[wptr_q] <= res_d;
      buf_wr_q[wptr_q]  <= fin.wr;
      buf_npc_q[wptr_q] <= fin.npc;
      buf_st_q[wptr_q]  <= fin.st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_valid_o     = (count_q != 2'd0);
  assign result_o        = buf_res_q[rptr_q];
  assign writes_result_o = buf_wr_q[rptr_q];
  assign next_pc_o       = buf_npc_q[rptr_q];
  assign status_o        = buf_st_q[rptr_q];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("output buffer overflow");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 2'd1)
    else $error("push lost");

  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && writes_result_o) |-> status_o == ST_DONE)
    else $error("write on flagged instruction");

endmodule

// ----- verif/mmix_integer_execute_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmix_integer_execute_unit_test
// Self-checking bench for the integer execute unit: directed corner cases,
// then random instructions with random idling on both channels. Every
// accepted instruction is predicted in order and checked against each
// result field.
// ----------------------------------------------------------------------------
module mmix_integer_execute_unit_test;
  import mmixeu_pkg::*;

  localparam logic [7:0] OP_MUL    = 8'h18;
  localparam logic [7:0] OP_DIV    = 8'h1c;
  localparam logic [7:0] OP_DIVU   = 8'h1e;
  localparam logic [7:0] OP_ADD    = 8'h20;
  localparam logic [7:0] OP_SUB    = 8'h24;
  localparam logic [7:0] OP_2ADDU  = 8'h28;
  localparam logic [7:0] OP_16ADDU = 8'h2e;
  localparam logic [7:0] OP_CMP    = 8'h30;
  localparam logic [7:0] OP_CMPU   = 8'h32;
  localparam logic [7:0] OP_NEG    = 8'h34;
  localparam logic [7:0] OP_SL     = 8'h38;
  localparam logic [7:0] OP_SR     = 8'h3c;
  localparam logic [7:0] OP_SRU    = 8'h3e;
  localparam logic [7:0] OP_BN     = 8'h40;
  localparam logic [7:0] OP_PBEVB  = 8'h5f;
  localparam logic [7:0] OP_CSN    = 8'h60;
  localparam logic [7:0] OP_CSEVI  = 8'h6f;
  localparam logic [7:0] OP_ZSN    = 8'h70;
  localparam logic [7:0] OP_ZSEVI  = 8'h7f;
  localparam logic [7:0] OP_LDB    = 8'h80;
  localparam logic [7:0] OP_LDOUI  = 8'h8f;
  localparam logic [7:0] OP_LDHT   = 8'h92;
  localparam logic [7:0] OP_LDHTI  = 8'h93;
  localparam logic [7:0] OP_CSWAP  = 8'h94;
  localparam logic [7:0] OP_LDUNC  = 8'h96;
  localparam logic [7:0] OP_LDUNCI = 8'h97;
  localparam logic [7:0] OP_PRELD  = 8'h9a;
  localparam logic [7:0] OP_PREGOI = 8'h9d;
  localparam logic [7:0] OP_GO     = 8'h9e;
  localparam logic [7:0] OP_GOI    = 8'h9f;
  localparam logic [7:0] OP_STB    = 8'ha0;
  localparam logic [7:0] OP_STOUI  = 8'haf;
  localparam logic [7:0] OP_STHT   = 8'hb2;
  localparam logic [7:0] OP_STUNCI = 8'hb7;
  localparam logic [7:0] OP_PREST  = 8'hba;
  localparam logic [7:0] OP_PRESTI = 8'hbb;
  localparam logic [7:0] OP_PUSHGO = 8'hbe;
  localparam logic [7:0] OP_PUSHGI = 8'hbf;
  localparam logic [7:0] OP_OR     = 8'hc0;
  localparam logic [7:0] OP_NXORI  = 8'hcf;
  localparam logic [7:0] OP_MUX    = 8'hd8;
  localparam logic [7:0] OP_MUXI   = 8'hd9;
  localparam logic [7:0] OP_MOR    = 8'hdc;
  localparam logic [7:0] OP_MORI   = 8'hdd;
  localparam logic [7:0] OP_MXOR   = 8'hde;
  localparam logic [7:0] OP_MXORI  = 8'hdf;
  localparam logic [7:0] OP_SETH   = 8'he0;
  localparam logic [7:0] OP_SETL   = 8'he3;
  localparam logic [7:0] OP_INCH   = 8'he4;
  localparam logic [7:0] OP_INCL   = 8'he7;
  localparam logic [7:0] OP_ORH    = 8'he8;
  localparam logic [7:0] OP_ORL    = 8'heb;
  localparam logic [7:0] OP_ANDNH  = 8'hec;
  localparam logic [7:0] OP_ANDNL  = 8'hef;
  localparam logic [7:0] OP_JMP    = 8'hf0;
  localparam logic [7:0] OP_JMPB   = 8'hf1;
  localparam logic [7:0] OP_PUSHJ  = 8'hf2;
  localparam logic [7:0] OP_PUSHJB = 8'hf3;
  localparam logic [7:0] OP_GETA   = 8'hf4;
  localparam logic [7:0] OP_GETAB  = 8'hf5;
  localparam logic [7:0] OP_PUT    = 8'hf6;
  localparam logic [7:0] OP_POP    = 8'hf8;
  localparam logic [7:0] OP_SWYM   = 8'hfd;
  localparam logic [7:0] OP_GET    = 8'hfe;

  localparam logic [63:0] BYTE_SPREAD = 64'h0101010101010101;
  localparam logic [63:0] MIN_NEG     = 64'h8000000000000000;
  localparam int          NUM_RANDOM  = 1500;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          DRAIN_WAIT  = 100;

  typedef struct packed {
    logic [63:0] result;
    logic        wr;
    logic [63:0] npc;
    logic [1:0]  st;
  } outcome_t;

  class exec_scoreboard;
    outcome_t expected_q[$];
    int       errors;

    function automatic logic cond_true(logic [7:0] cmd, logic [63:0] v);
      logic n, zr, od;
      n  = v[63];
      zr = (v == '0);
      od = v[0];
      case (cmd[3:1])
        3'd0: return n;
        3'd1: return zr;
        3'd2: return !n && !zr;
        3'd3: return od;
        3'd4: return !n;
        3'd5: return !zr;
        3'd6: return n || zr;
        default: return !od;
      endcase
    endfunction

    function automatic logic [63:0] offset(logic [7:0] cmd, logic [63:0] imm,
                                           logic [63:0] span);
      logic [63:0] v;
      v = imm;
      if (cmd[0]) v = v - span;
      return v << 2;
    endfunction

    function automatic logic [63:0] matrix(logic [63:0] y, logic [63:0] z,
                                           logic use_xor);
      logic [63:0] acc, a, b;
      acc = '0;
      for (int i = 0; i < 8; i++) begin
        a = ((y >> (8 * i)) & 64'hff) * BYTE_SPREAD;
        b = ((z >> i) & BYTE_SPREAD) * 64'hff;
        acc = use_xor ? (acc ^ (a & b)) : (acc | (a & b));
      end
      return acc;
    endfunction

    function automatic logic [63:0] signed_quot(logic [63:0] y, logic [63:0] z);
      logic [63:0] ay, az, q;
      ay = y[63] ? -y : y;
      az = z[63] ? -z : z;
      if (az == '0) return '0;
      q = ay / az;
      return (y[63] != z[63]) ? -q : q;
    endfunction

    function automatic outcome_t execute(instr_t t);
      outcome_t    o;
      logic [7:0]  c;
      logic [63:0] y, z, yz, wy, fill;
      c = t.cmd;
      y = t.y_value;
      z = c[0] ? {56'd0, t.op_z} : t.z_value;
      yz = {48'd0, t.op_y, t.op_z};
      wy = yz << {~c[1:0], 4'd0};
      o.result = '0;
      o.wr = 1'b1;
      o.npc = t.pc + 64'd4;
      o.st = ST_DONE;
      if (c >= OP_MUL && c < OP_DIV) o.result = y * z;
      else if (c >= OP_DIV && c < OP_DIVU) o.result = signed_quot(y, z);
      else if (c >= OP_DIVU && c < OP_ADD) o.result = (z == '0) ? '0 : y / z;
      else if (c >= OP_ADD && c < OP_SUB) o.result = y + z;
      else if (c >= OP_SUB && c < OP_2ADDU) o.result = y - z;
      else if (c >= OP_2ADDU && c < OP_CMP) o.result = (y << (c[2:1] + 1)) + z;
      else if (c >= OP_CMP && c < OP_CMPU)
        o.result = ($signed(y) > $signed(z)) ? 64'd1 :
                   (($signed(y) < $signed(z)) ? '1 : '0);
      else if (c >= OP_CMPU && c < OP_NEG)
        o.result = (y > z) ? 64'd1 : ((y < z) ? '1 : '0);
      else if (c >= OP_NEG && c < OP_SL) o.result = {56'd0, t.op_y} - z;
      else if (c >= OP_SL && c < OP_SR) o.result = (z >= 64) ? '0 : (y << z[5:0]);
      else if (c >= OP_SR && c < OP_SRU) begin
        fill = y[63] ? '1 : '0;
        o.result = (z >= 64) ? fill : 64'($signed(y) >>> z[5:0]);
      end else if (c >= OP_SRU && c < OP_BN) o.result = (z >= 64) ? '0 : (y >> z[5:0]);
      else if (c >= OP_BN && c <= OP_PBEVB) begin
        o.wr = 1'b0;
        if (cond_true(c, t.x_value)) o.npc = t.pc + offset(c, yz, 64'h10000);
      end else if (c >= OP_CSN && c <= OP_CSEVI) begin
        if (cond_true(c, y)) o.result = z;
        else begin
          o.result = t.x_value;
          o.wr = 1'b0;
        end
      end else if (c >= OP_ZSN && c <= OP_ZSEVI) o.result = cond_true(c, y) ? z : '0;
      else if ((c >= OP_LDB && c <= OP_LDOUI) || c == OP_LDHT || c == OP_LDHTI ||
               c == OP_LDUNC || c == OP_LDUNCI || c == OP_GO || c == OP_GOI ||
               (c >= OP_STB && c <= OP_STOUI) || (c >= OP_STHT && c <= OP_STUNCI) ||
               c == OP_PUSHGO || c == OP_PUSHGI || c == OP_PUSHJ || c == OP_PUSHJB ||
               (c >= OP_PUT && c <= OP_POP) || c == OP_GET)
        o.st = ST_ELSEWHERE;
      else if ((c >= OP_PRELD && c <= OP_PREGOI) || c == OP_PREST || c == OP_PRESTI ||
               c == OP_SWYM)
        o.wr = 1'b0;
      else if (c >= OP_OR && c <= OP_NXORI) begin
        case (c[3:1])
          3'd0: o.result = y | z;
          3'd1: o.result = y | ~z;
          3'd2: o.result = ~(y | z);
          3'd3: o.result = y ^ z;
          3'd4: o.result = y & z;
          3'd5: o.result = y & ~z;
          3'd6: o.result = ~(y & z);
          default: o.result = ~(y ^ z);
        endcase
      end else if (c == OP_MUX || c == OP_MUXI)
        o.result = (y & t.mux_mask) | (z & ~t.mux_mask);
      else if (c == OP_MOR || c == OP_MORI) o.result = matrix(y, z, 1'b0);
      else if (c == OP_MXOR || c == OP_MXORI) o.result = matrix(y, z, 1'b1);
      else if (c >= OP_SETH && c <= OP_SETL) o.result = wy;
      else if (c >= OP_INCH && c <= OP_INCL) o.result = t.x_value + wy;
      else if (c >= OP_ORH && c <= OP_ORL) o.result = t.x_value | wy;
      else if (c >= OP_ANDNH && c <= OP_ANDNL) o.result = t.x_value & wy;
      else if (c == OP_JMP || c == OP_JMPB) begin
        o.wr = 1'b0;
        o.npc = t.pc + offset(c, {40'd0, t.op_x, t.op_y, t.op_z}, 64'h1000000);
      end else if (c == OP_GETA || c == OP_GETAB)
        o.result = t.pc + offset(c, yz, 64'h10000);
      else o.st = ST_ILLEGAL;
      if (o.st != ST_DONE) begin
        o.result = '0;
        o.wr = 1'b0;
        o.npc = t.pc + 64'd4;
      end
      return o;
    endfunction

    task automatic report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function automatic void note_instr(instr_t t);
      expected_q.push_back(execute(t));
    endfunction

    task automatic check_result(logic [63:0] res, logic wr, logic [63:0] npc,
                                logic [1:0] st);
      outcome_t e;
      if (expected_q.size() == 0) begin
        report("result with no instruction outstanding");
        return;
      end
      e = expected_q.pop_front();
      if (res !== e.result) report($sformatf("result %h, want %h", res, e.result));
      if (wr !== e.wr) report($sformatf("writes_result %b, want %b", wr, e.wr));
      if (npc !== e.npc) report($sformatf("next_pc %h, want %h", npc, e.npc));
      if (st !== e.st) report($sformatf("status %0d, want %0d", st, e.st));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  cmd_i;
  logic [7:0]  op_x_i;
  logic [7:0]  op_y_i;
  logic [7:0]  op_z_i;
  logic [63:0] x_value_i;
  logic [63:0] y_value_i;
  logic [63:0] z_value_i;
  logic [63:0] pc_i;
  logic [63:0] mux_mask_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] result_o;
  logic        writes_result_o;
  logic [63:0] next_pc_o;
  logic [1:0]  status_o;

  exec_scoreboard sb;
  int unsigned    in_idle_pct;
  int unsigned    out_idle_pct;
  int unsigned    stall_left;
  int unsigned    cycles;

  mmix_integer_execute_unit dut (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] pick_word();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = MIN_NEG;
      3: v = 64'd1;
      4: v = 64'($urandom_range(0, 70));
      5: v = ~MIN_NEG;
      6: v = -64'($urandom_range(1, 9));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'hff;
      2: return 8'($urandom_range(0, 70));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic instr_t rand_instr();
    instr_t t;
    t.cmd = 8'($urandom);
    t.op_x = pick_byte();
    t.op_y = pick_byte();
    t.op_z = pick_byte();
    t.x_value = pick_word();
    t.y_value = pick_word();
    t.z_value = pick_word();
    t.pc = ($urandom_range(0, 3) == 0) ? pick_word() : {$urandom, $urandom};
    t.mux_mask = pick_word();
    return t;
  endfunction

  function automatic instr_t mk(logic [7:0] c, logic [7:0] x, logic [7:0] y,
                                logic [7:0] z, logic [63:0] xv, logic [63:0] yv,
                                logic [63:0] zv);
    instr_t t;
    t = '{cmd: c, op_x: x, op_y: y, op_z: z, x_value: xv, y_value: yv,
          z_value: zv, pc: 64'h0000_0000_0000_1000, mux_mask: 64'h00ff_00ff_f0f0_0f0f};
    return t;
  endfunction

  task automatic send_instr(instr_t t);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < in_idle_pct) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= t.cmd;
    op_x_i     <= t.op_x;
    op_y_i     <= t.op_y;
    op_z_i     <= t.op_z;
    x_value_i  <= t.x_value;
    y_value_i  <= t.y_value;
    z_value_i  <= t.z_value;
    pc_i       <= t.pc;
    mux_mask_i <= t.mux_mask;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_instr(t);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result(result_o, writes_result_o, next_pc_o, status_o);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 99) < out_idle_pct) begin
        stall_left <= gap_len() - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    instr_t directed[$];
    sb = new();
    cycles = 0;
    stall_left = 0;
    in_idle_pct = 20;
    out_idle_pct = 20;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    cmd_i = '0;
    op_x_i = '0;
    op_y_i = '0;
    op_z_i = '0;
    x_value_i = '0;
    y_value_i = '0;
    z_value_i = '0;
    pc_i = '0;
    mux_mask_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed.push_back(mk(OP_DIV, 0, 0, 0, 0, 64'd77, 64'd0));
    directed.push_back(mk(OP_DIVU, 0, 0, 0, 0, '1, 64'd0));
    directed.push_back(mk(OP_DIV, 0, 0, 0, 0, MIN_NEG, '1));
    directed.push_back(mk(OP_DIV, 0, 0, 0, 0, -64'd7, 64'd2));
    directed.push_back(mk(OP_DIV + 8'd1, 0, 0, 8'd0, 0, 64'd5, '1));
    directed.push_back(mk(OP_MUL + 8'd1, 0, 0, 8'hff, 0, '1, 0));
    directed.push_back(mk(OP_SL, 0, 0, 0, 0, '1, 64'd64));
    directed.push_back(mk(OP_SR, 0, 0, 0, 0, MIN_NEG, 64'd64));
    directed.push_back(mk(OP_SR + 8'd1, 0, 0, 8'd63, 0, MIN_NEG, 0));
    directed.push_back(mk(OP_SR, 0, 0, 0, 0, MIN_NEG, 64'd0));
    directed.push_back(mk(OP_SRU + 8'd1, 0, 0, 8'd200, 0, '1, 0));
    directed.push_back(mk(OP_CSN, 0, 0, 0, 64'h1234, 64'd5, 64'd9));
    directed.push_back(mk(OP_ZSN + 8'd1, 0, 0, 8'h55, 0, MIN_NEG, 0));
    directed.push_back(mk(OP_ANDNH, 0, 8'hff, 8'h00, '1, 0, 0));
    directed.push_back(mk(OP_ANDNL, 0, 8'h0f, 8'hf0, '1, 0, 0));
    directed.push_back(mk(OP_PRELD, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OP_SWYM, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OP_CSWAP, 0, 0, 0, '1, '1, '1));
    directed.push_back(mk(OP_LDB, 0, 0, 0, '1, '1, '1));
    directed.push_back(mk(OP_JMPB, 8'hff, 8'hff, 8'hff, 0, 0, 0));
    directed.push_back(mk(OP_GETAB, 0, 8'h00, 8'h00, 0, 0, 0));
    directed.push_back(mk(OP_BN + 8'd1, 0, 8'hff, 8'hff, MIN_NEG, 0, 0));
    directed.push_back(mk(OP_MUX, 0, 0, 0, 0, '1, 0));
    directed.push_back(mk(OP_MOR, 0, 0, 0, 0, 64'h0123456789abcdef, 64'h8040201008040201));
    directed.push_back(mk(OP_MXOR + 8'd1, 0, 0, 8'hff, 0, '1, 0));
    foreach (directed[i]) send_instr(directed[i]);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 250 == 0) begin
        in_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
        out_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
      end
      send_instr(rand_instr());
    end
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
